>>> hdl/sorted_table_binary_search_unit_macros.svh
// Assertion macros for the sorted table binary search unit.
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define STBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define STBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/stbs_pkg.sv
// Package for the sorted table binary search unit: defaults, field widths, command codes.
package stbs_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;
  localparam int DATA_WIDTH_DEF  = 32;
  localparam int INDEX_WIDTH     = 10;
  localparam int COUNT_WIDTH     = 11;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_t;

endpackage

>>> hdl/sorted_table_binary_search_unit.sv
// Sorted table binary search unit: table RAM, probe sequencer and result register.
//
// A transaction is taken when start is high and busy is low. A write (cmd 0) stores
// in_item_value at in_entry_index and gives no result; indexes at or beyond
// TABLE_DEPTH are dropped. A search (cmd 1) looks for in_item_value among entries
// 0 to n-1, n being the count loaded from cfg_wdata by cfg_we (saturated to
// TABLE_DEPTH), and gives one result: out_valid pulses for one cycle with out_found.
// The receiver cannot stall, so out_valid must be sampled in that cycle. A search
// holds busy while it probes; each probe is one read of the table RAM, so a search
// takes floor(log2(n)) + 1 probes at most (11 for 1024 entries) and the result is
// registered from the compare of the last probe. An empty range answers not found
// on the next cycle. Entries probed by a search must have been written since reset.
// The table should hold ascending signed values.
`include "sorted_table_binary_search_unit_macros.svh"

module sorted_table_binary_search_unit
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_cmd,
  input  logic [INDEX_WIDTH-1:0]       in_entry_index,
  input  logic signed [DATA_WIDTH-1:0] in_item_value,
  output logic                         out_valid,
  output logic                         out_found,
  input  logic                         cfg_we,
  input  logic [COUNT_WIDTH-1:0]       cfg_wdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  state_t                  state_r, state_nxt;
  logic [COUNT_WIDTH-1:0]  entries_r;
  logic [CW-1:0]           low_r, low_nxt;
  logic [CW-1:0]           hi_r, hi_nxt;
  logic [AW-1:0]           mid_r, mid_nxt;
  logic signed [DATA_WIDTH-1:0] key_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_found_r, out_found_nxt;

  logic                    accept;
  logic                    wr_en;
  logic [DATA_WIDTH-1:0]   rdata;
  logic [CW-1:0]           n_eff;
  logic [CW:0]             mid0_sum;
  logic [CW:0]             mid_up_sum;
  logic [CW:0]             mid_dn_sum;
  logic [CW-1:0]           low_up;
  logic                    cont_up;
  logic                    cont_dn;
  logic                    hit;
  logic                    below;

  assign accept = start && !busy;
  assign wr_en  = accept && (in_cmd == CMD_WRITE) &&
                  (32'(in_entry_index) < 32'(TABLE_DEPTH));

  stbs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(in_entry_index)),
    .wdata (in_item_value),
    .raddr (mid_nxt),
    .rdata (rdata)
  );

  always_comb begin
    if (32'(entries_r) > 32'(TABLE_DEPTH)) begin
      n_eff = CW'(TABLE_DEPTH);
    end else begin
      n_eff = CW'(entries_r);
    end
  end

  // Both successor midpoints are prepared from registers; the compare only selects.
  assign mid0_sum   = (CW+1)'(n_eff) - (CW+1)'(1);
  assign mid_up_sum = (CW+1)'(mid_r) + (CW+1)'(hi_r);
  assign mid_dn_sum = (CW+1)'(low_r) + (CW+1)'(mid_r) - (CW+1)'(1);
  assign low_up     = CW'(mid_r) + CW'(1);
  assign cont_up    = low_up < hi_r;
  assign cont_dn    = low_r < CW'(mid_r);
  assign hit        = ($signed(rdata) == key_r);
  assign below      = ($signed(rdata) < key_r);

  always_comb begin
    state_nxt     = state_r;
    low_nxt       = low_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = out_found_r;
    case (state_r)
      S_IDLE: begin
        low_nxt = '0;
        hi_nxt  = n_eff;
        mid_nxt = AW'(mid0_sum >> 1);
        if (accept && (in_cmd == CMD_SEARCH)) begin
          if (n_eff == '0) begin
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b0;
          end else begin
            state_nxt = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        if (hit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
        end else if (below) begin
          low_nxt = low_up;
          mid_nxt = AW'(mid_up_sum >> 1);
          if (!cont_up) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b0;
          end
        end else begin
          hi_nxt  = CW'(mid_r);
          mid_nxt = AW'(mid_dn_sum >> 1);
          if (!cont_dn) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            out_found_nxt = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      out_found_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_found_r <= out_found_nxt;
    end
    low_r <= low_nxt;
    hi_r  <= hi_nxt;
    mid_r <= mid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= '0;
    end else if (cfg_we) begin
      entries_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_item_value;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_found = out_found_r;

  `STBS_ASSERT_NOW(a_result_only_when_idle, clk, rst_n, out_valid, !busy, "result while searching")
  `STBS_ASSERT_NEXT(a_write_no_result, clk, rst_n, accept && (in_cmd == CMD_WRITE), !out_valid && !busy, "write gave a result")
  `STBS_ASSERT_NEXT(a_search_progress, clk, rst_n, accept && (in_cmd == CMD_SEARCH), busy || out_valid, "search transaction lost")
  `STBS_ASSERT_NOW(a_range_nonempty, clk, rst_n, state_r == S_SEARCH, (low_r < hi_r) && (CW'(mid_r) >= low_r) && (CW'(mid_r) < hi_r), "probe outside range")

endmodule

>>> hdl/stbs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/testbench.sv
// Testbench for the sorted table binary search unit: table writes and searches vs a predictor.
`timescale 1ns / 1ps

module testbench;
  import stbs_pkg::*;

  typedef struct packed {
    cmd_t                              cmd;
    logic [INDEX_WIDTH-1:0]            idx;
    logic signed [DATA_WIDTH_DEF-1:0]  val;
  } table_op_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic                              in_cmd = 1'b0;
  logic [INDEX_WIDTH-1:0]            in_entry_index = '0;
  logic signed [DATA_WIDTH_DEF-1:0]  in_item_value = '0;
  logic                              out_valid;
  logic                              out_found;
  logic                              cfg_we = 1'b0;
  logic [COUNT_WIDTH-1:0]            cfg_wdata = '0;

  table_op_t                         table_op_q[$];
  bit                                pending_found_q[$];
  logic signed [DATA_WIDTH_DEF-1:0]  tbl_shadow[TABLE_DEPTH_DEF];
  logic [COUNT_WIDTH-1:0]            range_shadow;
  logic signed [DATA_WIDTH_DEF-1:0]  gen_tbl[TABLE_DEPTH_DEF];
  int                                item_total;
  int                                sent_cnt;
  int                                err_cnt;
  bit                                taken;
  bit                                want_found;
  table_op_t                         next_op;

  sorted_table_binary_search_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_entry_index (in_entry_index),
    .in_item_value  (in_item_value),
    .out_valid      (out_valid),
    .out_found      (out_found),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic bit bsearch_finds(logic signed [DATA_WIDTH_DEF-1:0] key);
    int lo;
    int hi;
    int mid;
    int n;
    n = (range_shadow > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : int'(range_shadow);
    lo = 0;
    hi = n - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (tbl_shadow[mid] == key) return 1'b1;
      if (tbl_shadow[mid] < key) lo = mid + 1;
      else hi = mid - 1;
    end
    return 1'b0;
  endfunction

  function automatic logic signed [DATA_WIDTH_DEF-1:0] choose_key(int n);
    logic signed [DATA_WIDTH_DEF-1:0] k;
    if (n == 0) return $urandom;
    k = gen_tbl[$urandom_range(0, n - 1)];
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return k;
      4, 5: return $urandom_range(0, 1) ? k + 1 : k - 1;
      6, 7: return $urandom;
      8: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      default: return '0;
    endcase
  endfunction

  task automatic push_write(int idx, logic signed [DATA_WIDTH_DEF-1:0] val);
    table_op_q.push_back('{CMD_WRITE, idx[INDEX_WIDTH-1:0], val});
    gen_tbl[idx] = val;
    item_total++;
  endtask

  task automatic push_search(logic signed [DATA_WIDTH_DEF-1:0] key);
    logic [INDEX_WIDTH-1:0] junk_idx;
    junk_idx = INDEX_WIDTH'($urandom_range(0, TABLE_DEPTH_DEF - 1));
    table_op_q.push_back('{CMD_SEARCH, junk_idx, key});
    item_total++;
  endtask

  // ascending values spread over the whole signed range, duplicates allowed
  task automatic fill_sorted(int m);
    longint step_max;
    longint v;
    step_max = (64'sd1 << 32) / (m + 1);
    v = -(64'sd1 << 31) + longint'($urandom_range(0, 32'(step_max)));
    for (int i = 0; i < m; i++) begin
      push_write(i, v[31:0]);
      v += longint'($urandom_range(0, 32'(step_max)));
    end
  endtask

  task automatic wait_idle();
    while (table_op_q.size() != 0 || start || busy || pending_found_q.size() != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_range(int n);
    wait_idle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = COUNT_WIDTH'(n);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // acceptance, prediction and result check
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) range_shadow = cfg_wdata;
      if (start && !busy) begin
        taken = 1'b1;
        if (in_cmd == CMD_WRITE) tbl_shadow[in_entry_index] = in_item_value;
        else pending_found_q.push_back(bsearch_finds(in_item_value));
      end
      if (out_valid) begin
        if (pending_found_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result transaction: found=%b", out_found);
        end else begin
          want_found = pending_found_q.pop_front();
          if (out_found !== want_found) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("found mismatch: expected %0b, got %b", want_found, out_found);
          end
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n && (!start || taken)) begin
      taken = 1'b0;
      if (table_op_q.size() != 0 &&
          ((sent_cnt >= 200 && sent_cnt < 500) || $urandom_range(0, 99) >= 30)) begin
        next_op = table_op_q.pop_front();
        start <= 1'b1;
        in_cmd <= next_op.cmd;
        in_entry_index <= next_op.idx;
        in_item_value <= next_op.val;
        sent_cnt++;
      end else begin
        start <= 1'b0;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int n;
    int eff;
    int r;
    range_shadow = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // empty range after reset
    push_search('0);
    push_search(32'sh8000_0000);
    push_search(32'sh7fff_ffff);
    push_write(0, 32'sh8000_0000);
    push_write(1, -1000);
    push_write(2, -1);
    push_write(3, 0);
    push_write(4, 1);
    push_write(5, 77);
    push_write(6, 5000);
    push_write(7, 32'sh7fff_ffff);
    set_range(8);
    push_search(32'sh8000_0000);
    push_search(32'sh7fff_ffff);
    push_search(0);
    push_search(77);
    push_search(-2);
    push_search(2);
    push_search(32'sh7fff_fffe);
    set_range(1);
    push_search(32'sh8000_0000);
    push_search(0);
    set_range(0);
    push_search(32'sh8000_0000);

    fill_sorted(TABLE_DEPTH_DEF);

    for (int ph = 0; item_total < 1350; ph++) begin
      if (ph == 0) n = 1024;
      else if (ph == 1) n = 2047;
      else if (ph == 2) n = 1025;
      else begin
        r = $urandom_range(0, 9);
        if (r < 4) n = $urandom_range(1, 16);
        else if (r < 8) n = $urandom_range(17, 1023);
        else if (r == 8) n = 1024;
        else n = $urandom_range(1025, 2047);
      end
      eff = (n > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : n;
      if (eff <= 16 && $urandom_range(0, 1)) fill_sorted(eff);
      set_range(n);
      repeat ($urandom_range(15, 35)) begin
        // occasional overwrite leaves the table unsorted
        if ($urandom_range(0, 9) == 0)
          push_write($urandom_range(0, TABLE_DEPTH_DEF - 1), $urandom);
        else
          push_search(choose_key(eff));
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (err_cnt == 0 && pending_found_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/stbs_pkg.sv
hdl/stbs_ram.sv
hdl/sorted_table_binary_search_unit.sv
tb/testbench.sv
